[src/dzhp_pkg.sv]
// dzhp_pkg: beat types, result kinds, error codes and gzip header constants
// for the dictzip header parser. No dependencies.
`timescale 1ns / 1ps

package dzhp_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] chunk_index;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_size;
    logic [15:0] uncompressed_chunk_length;
    logic [15:0] chunk_total;
    logic [31:0] data_offset;
    logic [2:0]  error_code;
  } out_beat_t;

  // result kinds
  localparam logic [1:0] KIND_CHUNK = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_BAD_METHOD  = 3'd2;
  localparam logic [2:0] ERR_NO_EXTRA    = 3'd3;
  localparam logic [2:0] ERR_BAD_VERSION = 3'd4;

  // gzip / dictzip constants
  localparam logic [7:0]  GZ_ID1     = 8'h1f;
  localparam logic [7:0]  GZ_ID2     = 8'h8b;
  localparam logic [7:0]  GZ_DEFLATE = 8'd8;
  localparam logic [15:0] RA_ID      = 16'h5241;  // 'R' 'A'
  localparam logic [15:0] RA_VERSION = 16'd1;
  localparam logic [15:0] HCRC_BYTES = 16'd2;

endpackage

[src/dictzip_header_parser.sv]
// dictzip_header_parser: top level with input register, parser core and
// result register. Depends on dzhp_pkg and dzhp_core.
// Path: input register, then the parser core, then the result register that drives result_valid.
// Throughput: one byte beat per cycle, sustained; the only stall is a full
// result register that the consumer is not taking.
// Reset (rst, synchronous): empties both registers and returns the parser to idle.
`timescale 1ns / 1ps

module dictzip_header_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  dzhp_pkg::in_beat_t  byte_data,
  output logic                result_valid,
  input  logic                result_ready,
  output dzhp_pkg::out_beat_t result_data
);

  // input register
  logic               in_full;
  dzhp_pkg::in_beat_t in_beat;

  // core handshake
  logic                advance;
  logic                core_emit;
  dzhp_pkg::out_beat_t core_res;

  // Advance the held beat into the parser whenever the result register is
  // empty or being drained this cycle; every beat may produce one result.
  assign advance    = in_full && (!result_valid || result_ready);
  assign byte_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_ready) begin
      in_full <= byte_valid;
    end
  end

  // hold the payload until it advances
  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      in_beat <= byte_data;
    end
  end

  dzhp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .beat (in_beat),
    .emit (core_emit),
    .res  (core_res)
  );

  // result register: load a fresh result, otherwise drop the valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && core_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_emit) begin
      result_data <= core_res;
    end
  end

endmodule

[src/dzhp_core.sv]
// dzhp_core: parser state registers and the per-byte next-state and result
// logic. Depends on dzhp_pkg.
`timescale 1ns / 1ps

module dzhp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  dzhp_pkg::in_beat_t  beat,
  output logic                emit,
  output dzhp_pkg::out_beat_t res
);

  localparam logic [3:0] P_IDLE     = 4'd0;
  localparam logic [3:0] P_HDR      = 4'd1;
  localparam logic [3:0] P_XLEN     = 4'd2;
  localparam logic [3:0] P_SUBHDR   = 4'd3;
  localparam logic [3:0] P_SKIP     = 4'd4;
  localparam logic [3:0] P_RA_VER   = 4'd5;
  localparam logic [3:0] P_RA_LEN   = 4'd6;
  localparam logic [3:0] P_RA_CNT   = 4'd7;
  localparam logic [3:0] P_RA_SIZES = 4'd8;
  localparam logic [3:0] P_NAME     = 4'd9;
  localparam logic [3:0] P_COMMENT  = 4'd10;
  localparam logic [3:0] P_HCRC     = 4'd11;
  localparam logic [3:0] P_FINISH   = 4'd12;
  localparam logic [3:0] P_PEND     = 4'd13;

  // optional-part stages
  localparam logic [1:0] OPT_NAME    = 2'd0;
  localparam logic [1:0] OPT_COMMENT = 2'd1;
  localparam logic [1:0] OPT_HCRC    = 2'd2;

  // flags: [2] FCOMMENT, [1] FNAME, [0] FHCRC
  function automatic logic [3:0] goto_opt(input logic [1:0] from,
                                          input logic [2:0] flags);
    logic [3:0] p;
    p = P_FINISH;
    if (from <= OPT_HCRC && flags[0]) p = P_HCRC;
    if (from <= OPT_COMMENT && flags[2]) p = P_COMMENT;
    if (from == OPT_NAME && flags[1]) p = P_NAME;
    return p;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  logic [3:0]  phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [2:0]  header_flags, header_flags_next;
  logic [31:0] extra_end, extra_end_next;
  logic [15:0] subfield_id, subfield_id_next;
  logic [7:0]  field_accumulator, field_accumulator_next;
  logic [15:0] bytes_to_skip, bytes_to_skip_next;
  logic [15:0] chunks_remaining, chunks_remaining_next;
  logic [15:0] chunk_counter, chunk_counter_next;
  logic [31:0] running_offset, running_offset_next;
  logic [15:0] chunk_length_reg, chunk_length_reg_next;
  logic [15:0] total_chunks, total_chunks_next;
  logic [1:0]  sub_count, sub_count_next;

  // state as seen by this byte (start_req restarts from a clean header)
  logic [3:0]  c_phase;
  logic [31:0] c_pos, c_extra_end, c_running_offset;
  logic [2:0]  c_flags;
  logic [15:0] c_id, c_bts, c_cr, c_counter, c_clen, c_total;
  logic [7:0]  c_acc;
  logic [1:0]  c_sc;

  logic [7:0]  b;
  logic [31:0] bp_inc;
  logic [15:0] v;
  logic [3:0]  es_phase;
  logic [2:0]  err;
  logic        chunk;

  always_comb begin
    b = beat.file_byte;
    if (beat.start_req) begin
      c_phase = P_HDR;
      c_pos = '0; c_extra_end = '0; c_running_offset = '0; c_flags = '0;
      c_id = '0; c_bts = '0; c_cr = '0; c_counter = '0; c_clen = '0;
      c_total = '0; c_acc = '0; c_sc = '0;
    end else begin
      c_phase = phase;
      c_pos = byte_position; c_extra_end = extra_end;
      c_running_offset = running_offset; c_flags = header_flags;
      c_id = subfield_id; c_bts = bytes_to_skip; c_cr = chunks_remaining;
      c_counter = chunk_counter; c_clen = chunk_length_reg;
      c_total = total_chunks; c_acc = field_accumulator; c_sc = sub_count;
    end

    bp_inc   = (&c_pos) ? c_pos : c_pos + 32'd1;
    v        = {b, c_acc};
    es_phase = (bp_inc < c_extra_end) ? P_SUBHDR : goto_opt(OPT_NAME, c_flags);

    phase_next             = c_phase;
    byte_position_next     = (c_phase == P_IDLE) ? c_pos : bp_inc;
    header_flags_next      = c_flags;
    extra_end_next         = c_extra_end;
    subfield_id_next       = c_id;
    field_accumulator_next = c_acc;
    bytes_to_skip_next     = c_bts;
    chunks_remaining_next  = c_cr;
    chunk_counter_next     = c_counter;
    running_offset_next    = c_running_offset;
    chunk_length_reg_next  = c_clen;
    total_chunks_next      = c_total;
    sub_count_next         = c_sc;
    err   = dzhp_pkg::ERR_NONE;
    chunk = 1'b0;
    emit  = 1'b0;
    res   = '0;

    unique case (c_phase)
      P_IDLE: begin
      end
      P_HDR: begin
        if ((c_pos == 32'd0 && b != dzhp_pkg::GZ_ID1) ||
            (c_pos == 32'd1 && b != dzhp_pkg::GZ_ID2)) begin
          err = dzhp_pkg::ERR_BAD_MAGIC;
        end else if (c_pos == 32'd2 && b != dzhp_pkg::GZ_DEFLATE) begin
          err = dzhp_pkg::ERR_BAD_METHOD;
        end else if (c_pos == 32'd3) begin
          header_flags_next = {b[4], b[3], b[1]};
          if (!b[2]) err = dzhp_pkg::ERR_NO_EXTRA;
        end
        if (err == dzhp_pkg::ERR_NONE && c_pos >= 32'd9) begin
          phase_next     = P_XLEN;
          sub_count_next = 2'd0;
        end
      end
      P_XLEN: begin
        if (c_sc == 2'd0) begin
          field_accumulator_next = b;
          sub_count_next         = 2'd1;
        end else begin
          extra_end_next = sat_add(bp_inc, v);
          sub_count_next = 2'd0;
          // new end lies past bp_inc exactly when xlen is nonzero and bp_inc is not already saturated
          phase_next = (v != 16'd0 && !(&bp_inc)) ? P_SUBHDR
                                                   : goto_opt(OPT_NAME, c_flags);
        end
      end
      P_SUBHDR: begin
        case (c_sc)
          2'd0: begin
            subfield_id_next = {b, 8'd0};
            sub_count_next   = 2'd1;
          end
          2'd1: begin
            subfield_id_next = {c_id[15:8], b};
            sub_count_next   = 2'd2;
          end
          2'd2: begin
            field_accumulator_next = b;
            sub_count_next         = 2'd3;
          end
          default: begin
            sub_count_next = 2'd0;
            if (c_id == dzhp_pkg::RA_ID) begin
              phase_next = P_RA_VER;
            end else if (v == 16'd0) begin
              phase_next = es_phase;
            end else begin
              bytes_to_skip_next = v;
              phase_next         = P_SKIP;
            end
          end
        endcase
      end
      P_SKIP: begin
        bytes_to_skip_next = c_bts - 16'd1;
        if (c_bts == 16'd1) begin
          sub_count_next = 2'd0;
          phase_next     = es_phase;
        end
      end
      P_RA_VER, P_RA_LEN, P_RA_CNT, P_RA_SIZES: begin
        if (c_sc == 2'd0) begin
          field_accumulator_next = b;
          sub_count_next         = 2'd1;
        end else begin
          sub_count_next = 2'd0;
          if (c_phase == P_RA_VER) begin
            if (v != dzhp_pkg::RA_VERSION) err = dzhp_pkg::ERR_BAD_VERSION;
            else phase_next = P_RA_LEN;
          end else if (c_phase == P_RA_LEN) begin
            chunk_length_reg_next = v;
            phase_next            = P_RA_CNT;
          end else if (c_phase == P_RA_CNT) begin
            total_chunks_next     = v;
            chunks_remaining_next = v;
            running_offset_next   = '0;
            phase_next            = (v == 16'd0) ? es_phase : P_RA_SIZES;
          end else begin
            chunk                         = 1'b1;
            emit                          = 1'b1;
            res.kind                      = dzhp_pkg::KIND_CHUNK;
            res.chunk_index               = c_counter;
            res.chunk_offset              = c_running_offset;
            res.chunk_size                = v;
            res.uncompressed_chunk_length = c_clen;
            res.chunk_total               = c_total;
            chunk_counter_next    = c_counter + 16'd1;
            running_offset_next   = sat_add(c_running_offset, v);
            chunks_remaining_next = c_cr - 16'd1;
            if (c_cr == 16'd1) phase_next = es_phase;
          end
        end
      end
      P_NAME: begin
        if (b == 8'd0) phase_next = goto_opt(OPT_COMMENT, c_flags);
      end
      P_COMMENT: begin
        if (b == 8'd0) phase_next = goto_opt(OPT_HCRC, c_flags);
      end
      P_HCRC: begin
        bytes_to_skip_next = c_bts - 16'd1;
        if (c_bts == 16'd1) phase_next = P_FINISH;
      end
      P_PEND: begin
        emit                          = 1'b1;
        res.kind                      = dzhp_pkg::KIND_DONE;
        res.uncompressed_chunk_length = c_clen;
        res.chunk_total               = c_total;
        res.data_offset               = c_pos;
        phase_next                    = P_IDLE;
      end
      default: begin
        phase_next = P_IDLE;
      end
    endcase

    // entering the header CRC always skips two bytes
    if (phase_next == P_HCRC && c_phase != P_HCRC) bytes_to_skip_next = dzhp_pkg::HCRC_BYTES;

    if (err != dzhp_pkg::ERR_NONE) begin
      emit           = 1'b1;
      res            = '0;
      res.kind       = dzhp_pkg::KIND_ERROR;
      res.error_code = err;
      phase_next     = P_IDLE;
    end else if (phase_next == P_FINISH) begin
      if (chunk) begin
        phase_next = P_PEND;
      end else begin
        // report the table as it stands after this byte (an empty RA count clears it)
        emit                          = 1'b1;
        res.kind                      = dzhp_pkg::KIND_DONE;
        res.uncompressed_chunk_length = chunk_length_reg_next;
        res.chunk_total               = total_chunks_next;
        res.data_offset               = bp_inc;
        phase_next                    = P_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= P_IDLE;
      byte_position     <= '0;
      header_flags      <= '0;
      extra_end         <= '0;
      subfield_id       <= '0;
      field_accumulator <= '0;
      bytes_to_skip     <= '0;
      chunks_remaining  <= '0;
      chunk_counter     <= '0;
      running_offset    <= '0;
      chunk_length_reg  <= '0;
      total_chunks      <= '0;
      sub_count         <= '0;
    end else if (en) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      header_flags      <= header_flags_next;
      extra_end         <= extra_end_next;
      subfield_id       <= subfield_id_next;
      field_accumulator <= field_accumulator_next;
      bytes_to_skip     <= bytes_to_skip_next;
      chunks_remaining  <= chunks_remaining_next;
      chunk_counter     <= chunk_counter_next;
      running_offset    <= running_offset_next;
      chunk_length_reg  <= chunk_length_reg_next;
      total_chunks      <= total_chunks_next;
      sub_count         <= sub_count_next;
    end
  end

endmodule

[src/dzhp_checker.sv]
// dzhp_checker: port-level assertions for dictzip_header_parser, bound to
// the top level below. Depends on dzhp_pkg.
`timescale 1ns / 1ps

module dzhp_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input dzhp_pkg::out_beat_t result_data
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result beat changed while stalled");

  // nothing leaves the block right after reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // an error carries a nonzero code and no chunk or offset data
  a_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.kind == dzhp_pkg::KIND_ERROR |->
      result_data.error_code != dzhp_pkg::ERR_NONE &&
      result_data.data_offset == 32'd0 && result_data.chunk_total == 16'd0)
    else $error("malformed error result");

  // non-error results carry no error code
  a_noerr: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.kind != dzhp_pkg::KIND_ERROR |->
      result_data.error_code == dzhp_pkg::ERR_NONE)
    else $error("error code on a non-error result");

  // a chunk entry comes only from a table with at least one chunk
  a_chunk: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.kind == dzhp_pkg::KIND_CHUNK |->
      result_data.chunk_total != 16'd0 && result_data.data_offset == 32'd0)
    else $error("chunk entry without a chunk table");

endmodule

bind dictzip_header_parser dzhp_checker u_dzhp_checker (.*);

[tb/sv/dictzip_header_parser_test.sv]
// dictzip_header_parser_test: self-checking bench for the dictzip header parser.
// Feeds crafted and random gzip headers, predicts chunk/done/error records.
// Depends on dzhp_pkg and dictzip_header_parser.
`timescale 1ns / 1ps

module dictzip_header_parser_test;

  // gzip FLG bits that steer the optional header parts
  localparam logic [7:0] FLG_HCRC    = 8'h02;
  localparam logic [7:0] FLG_EXTRA   = 8'h04;
  localparam logic [7:0] FLG_NAME    = 8'h08;
  localparam logic [7:0] FLG_COMMENT = 8'h10;

  localparam int ITEM_TARGET  = 550;   // byte beats to offer in total
  localparam int HOLD_CYCLES  = 150;   // long consumer hold-off
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat moving on either side

  // Parse phases of the predictor; they follow the header layout in order.
  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR, PH_XLEN, PH_SUBHDR, PH_SKIP, PH_RA_VER, PH_RA_LEN,
    PH_RA_CNT, PH_RA_SIZES, PH_NAME, PH_COMMENT, PH_HCRC, PH_FINISH, PH_PEND
  } parse_phase_t;

  // Scoreboard: tracks the header walk byte by byte and holds the records
  // the parser owes us, oldest first.
  class dzhp_scoreboard;
    parse_phase_t        phase;
    logic [31:0]         byte_pos;
    logic [31:0]         extra_end;
    logic [31:0]         run_off;
    logic [7:0]          flags;
    logic [15:0]         sub_id;
    logic [15:0]         acc;
    logic [15:0]         skip_left;
    logic [15:0]         chunks_left;
    logic [15:0]         chunk_idx;
    logic [15:0]         chunk_len;
    logic [15:0]         chunk_cnt;
    logic [1:0]          sub_cnt;
    dzhp_pkg::out_beat_t header_results[$];
    int unsigned         fail_count;

    function new();
      clear();
      fail_count = 0;
    endfunction

    function void clear();
      phase       = PH_IDLE;
      byte_pos    = '0;
      extra_end   = '0;
      run_off     = '0;
      flags       = '0;
      sub_id      = '0;
      acc         = '0;
      skip_left   = '0;
      chunks_left = '0;
      chunk_idx   = '0;
      chunk_len   = '0;
      chunk_cnt   = '0;
      sub_cnt     = '0;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    // Advance to the first optional part at or after the given stage
    // (0 name, 1 comment, 2 header CRC, 3 nothing left).
    function void goto_optional(int from);
      if (from <= 0 && (flags & FLG_NAME) != 0) begin
        phase = PH_NAME;
      end else if (from <= 1 && (flags & FLG_COMMENT) != 0) begin
        phase = PH_COMMENT;
      end else if (from <= 2 && (flags & FLG_HCRC) != 0) begin
        skip_left = dzhp_pkg::HCRC_BYTES;
        phase     = PH_HCRC;
      end else begin
        phase = PH_FINISH;
      end
    endfunction

    // A new subfield begins only while still inside the extra field.
    function void end_subfield();
      sub_cnt = '0;
      if (byte_pos < extra_end) phase = PH_SUBHDR;
      else goto_optional(0);
    endfunction

    function int outstanding();
      return header_results.size();
    endfunction

    // Walk one accepted byte beat and queue whatever record it produces.
    function void note_byte(dzhp_pkg::in_beat_t beat);
      logic [7:0]          b;
      logic [31:0]         pos;
      logic [15:0]         v;
      logic [2:0]          err;
      bit                  emitted;
      dzhp_pkg::out_beat_t r;
      b       = beat.file_byte;
      err     = dzhp_pkg::ERR_NONE;
      emitted = 1'b0;
      r       = '0;
      if (beat.start_req) begin
        clear();
        phase = PH_HDR;
      end
      if (phase == PH_IDLE) return;
      pos = byte_pos;
      if (byte_pos != 32'hffff_ffff) byte_pos++;

      case (phase)
        PH_HDR: begin
          if ((pos == 0 && b != dzhp_pkg::GZ_ID1) ||
              (pos == 1 && b != dzhp_pkg::GZ_ID2)) begin
            err = dzhp_pkg::ERR_BAD_MAGIC;
          end else if (pos == 2 && b != dzhp_pkg::GZ_DEFLATE) begin
            err = dzhp_pkg::ERR_BAD_METHOD;
          end else if (pos == 3) begin
            flags = b;
            if ((b & FLG_EXTRA) == 0) err = dzhp_pkg::ERR_NO_EXTRA;
          end
          if (err == dzhp_pkg::ERR_NONE && pos >= 9) begin
            phase   = PH_XLEN;
            sub_cnt = '0;
          end
        end
        PH_XLEN: begin
          if (sub_cnt == 0) begin
            acc     = {8'h00, b};
            sub_cnt = 2'd1;
          end else begin
            extra_end = sat_add(byte_pos, {16'h0000, b, acc[7:0]});
            end_subfield();
          end
        end
        PH_SUBHDR: begin
          case (sub_cnt)
            2'd0: begin
              sub_id  = {b, 8'h00};
              sub_cnt = 2'd1;
            end
            2'd1: begin
              sub_id[7:0] = b;
              sub_cnt     = 2'd2;
            end
            2'd2: begin
              acc     = {8'h00, b};
              sub_cnt = 2'd3;
            end
            default: begin
              v       = {b, acc[7:0]};
              sub_cnt = '0;
              // an RA subfield is parsed by content, its length is not used
              if (sub_id == dzhp_pkg::RA_ID) begin
                phase = PH_RA_VER;
              end else if (v == 0) begin
                end_subfield();
              end else begin
                skip_left = v;
                phase     = PH_SKIP;
              end
            end
          endcase
        end
        PH_SKIP: begin
          skip_left--;
          if (skip_left == 0) end_subfield();
        end
        PH_RA_VER, PH_RA_LEN, PH_RA_CNT, PH_RA_SIZES: begin
          if (sub_cnt == 0) begin
            acc     = {8'h00, b};
            sub_cnt = 2'd1;
          end else begin
            v       = {b, acc[7:0]};
            sub_cnt = '0;
            case (phase)
              PH_RA_VER: begin
                if (v != dzhp_pkg::RA_VERSION) err = dzhp_pkg::ERR_BAD_VERSION;
                else phase = PH_RA_LEN;
              end
              PH_RA_LEN: begin
                chunk_len = v;
                phase     = PH_RA_CNT;
              end
              PH_RA_CNT: begin
                chunk_cnt   = v;
                chunks_left = v;
                run_off     = '0;
                if (v == 0) end_subfield();
                else phase = PH_RA_SIZES;
              end
              default: begin
                r.kind                      = dzhp_pkg::KIND_CHUNK;
                r.chunk_index               = chunk_idx;
                r.chunk_offset              = run_off;
                r.chunk_size                = v;
                r.uncompressed_chunk_length = chunk_len;
                r.chunk_total               = chunk_cnt;
                emitted                     = 1'b1;
                chunk_idx++;
                run_off = sat_add(run_off, {16'h0000, v});
                chunks_left--;
                if (chunks_left == 0) end_subfield();
              end
            endcase
          end
        end
        PH_NAME: begin
          if (b == 0) goto_optional(1);
        end
        PH_COMMENT: begin
          if (b == 0) goto_optional(2);
        end
        PH_HCRC: begin
          skip_left--;
          if (skip_left == 0) goto_optional(3);
        end
        PH_PEND: begin
          // completion deferred by a chunk record on the last header byte
          r.kind                      = dzhp_pkg::KIND_DONE;
          r.uncompressed_chunk_length = chunk_len;
          r.chunk_total               = chunk_cnt;
          r.data_offset               = pos;
          phase                       = PH_IDLE;
          header_results.insert(header_results.size(), r);
          return;
        end
        default: begin
          phase = PH_IDLE;
          return;
        end
      endcase

      if (err != dzhp_pkg::ERR_NONE) begin
        r            = '0;
        r.kind       = dzhp_pkg::KIND_ERROR;
        r.error_code = err;
        phase        = PH_IDLE;
        header_results.insert(header_results.size(), r);
        return;
      end
      if (phase == PH_FINISH) begin
        if (emitted) begin
          phase = PH_PEND;
        end else begin
          r.kind                      = dzhp_pkg::KIND_DONE;
          r.uncompressed_chunk_length = chunk_len;
          r.chunk_total               = chunk_cnt;
          r.data_offset               = byte_pos;
          phase                       = PH_IDLE;
          header_results.insert(header_results.size(), r);
          return;
        end
      end
      if (emitted) header_results.insert(header_results.size(), r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fail_count++;
      end
    endfunction

    // Compare one accepted result beat with the oldest owed record.
    function void check_result(dzhp_pkg::out_beat_t got);
      dzhp_pkg::out_beat_t want;
      if (header_results.size() == 0) begin
        $error("unexpected result beat, kind %0d", got.kind);
        fail_count++;
        return;
      end
      want = header_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("chunk_index", 32'(want.chunk_index), 32'(got.chunk_index));
      check_field("chunk_offset", want.chunk_offset, got.chunk_offset);
      check_field("chunk_size", 32'(want.chunk_size), 32'(got.chunk_size));
      check_field("uncompressed_chunk_length", 32'(want.uncompressed_chunk_length),
                  32'(got.uncompressed_chunk_length));
      check_field("chunk_total", 32'(want.chunk_total), 32'(got.chunk_total));
      check_field("data_offset", want.data_offset, got.data_offset);
      check_field("error_code", 32'(want.error_code), 32'(got.error_code));
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                byte_valid;
  logic                byte_ready;
  dzhp_pkg::in_beat_t  byte_data;
  logic                result_valid;
  logic                result_ready;
  dzhp_pkg::out_beat_t result_data;

  dzhp_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int quiet_cycles;
  int hold_requests;

  logic [7:0] file_q[$];   // bytes of the file being built
  logic [7:0] extra_q[$];  // subfields of its extra field, before XLEN is known

  dictzip_header_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both channels on the rising edge; inputs only move on the falling one.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result_data);
      if (byte_valid && byte_ready) sb.note_byte(byte_data);
    end
  end

  // Count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("dictzip_header_parser: mismatch");
    $finish;
  end

  // Consumer: stall at random, or hold off for a long stretch on request so
  // the parser backs up into its input.
  initial begin
    int holds_done;
    holds_done   = 0;
    result_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done   = hold_requests;
        result_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        result_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 34;
        recv_idle_pct = 49;
      end
      1: begin
        send_idle_pct = 49;
        recv_idle_pct = 34;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offer one byte beat, maybe after an idle gap, and hold it until taken.
  task automatic send_beat(input logic [7:0] value, input logic first);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    byte_data.file_byte = value;
    byte_data.start_req = first;
    byte_valid          = 1'b1;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_beat(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Send the built file, start marked on its first byte; stop early at cut.
  task automatic send_file(input int cut);
    for (int i = 0; i < file_q.size() && i < cut; i++) send_beat(file_q[i], i == 0);
  endtask

  // Fixed ten-byte gzip header: magic, deflate, flags, then mtime/xfl/os.
  task automatic start_header(input logic [7:0] flg);
    file_q.delete();
    extra_q.delete();
    file_q.insert(file_q.size(), dzhp_pkg::GZ_ID1);
    file_q.insert(file_q.size(), dzhp_pkg::GZ_ID2);
    file_q.insert(file_q.size(), dzhp_pkg::GZ_DEFLATE);
    file_q.insert(file_q.size(), flg);
    repeat (6) file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
  endtask

  task automatic add_other_sub(input logic [15:0] id, input logic [15:0] len);
    extra_q.insert(extra_q.size(), id[15:8]);
    extra_q.insert(extra_q.size(), id[7:0]);
    extra_q.insert(extra_q.size(), len[7:0]);
    extra_q.insert(extra_q.size(), len[15:8]);
    repeat (len) extra_q.insert(extra_q.size(), 8'($urandom_range(0, 255)));
  endtask

  // RA subfield: version, chunk length, chunk count, then one size per chunk.
  task automatic add_ra_sub(input logic [15:0] ver, input logic [15:0] clen,
                            input int count);
    logic [15:0] len;
    logic [15:0] sz;
    len = 16'(6 + 2 * count);
    extra_q.insert(extra_q.size(), dzhp_pkg::RA_ID[15:8]);
    extra_q.insert(extra_q.size(), dzhp_pkg::RA_ID[7:0]);
    extra_q.insert(extra_q.size(), len[7:0]);
    extra_q.insert(extra_q.size(), len[15:8]);
    extra_q.insert(extra_q.size(), ver[7:0]);
    extra_q.insert(extra_q.size(), ver[15:8]);
    extra_q.insert(extra_q.size(), clen[7:0]);
    extra_q.insert(extra_q.size(), clen[15:8]);
    extra_q.insert(extra_q.size(), count[7:0]);
    extra_q.insert(extra_q.size(), count[15:8]);
    repeat (count) begin
      case ($urandom_range(0, 7))
        0:       sz = 16'h0000;
        1:       sz = 16'hffff;
        default: sz = 16'($urandom_range(0, 65535));
      endcase
      extra_q.insert(extra_q.size(), sz[7:0]);
      extra_q.insert(extra_q.size(), sz[15:8]);
    end
  endtask

  // Write XLEN (skewed by adj to force overrun or underrun), then the subfields.
  task automatic close_extra(input int adj);
    int xlen;
    xlen = extra_q.size() + adj;
    if (xlen < 0) xlen = 0;
    file_q.insert(file_q.size(), xlen[7:0]);
    file_q.insert(file_q.size(), xlen[15:8]);
    foreach (extra_q[i]) file_q.insert(file_q.size(), extra_q[i]);
    extra_q.delete();
  endtask

  // Optional name and comment (NUL terminated) and the two header CRC bytes.
  task automatic add_tail(input logic [7:0] flg);
    if ((flg & FLG_NAME) != 0) begin
      repeat ($urandom_range(0, 3)) file_q.insert(file_q.size(), 8'($urandom_range(1, 255)));
      file_q.insert(file_q.size(), 8'h00);
    end
    if ((flg & FLG_COMMENT) != 0) begin
      repeat ($urandom_range(0, 3)) file_q.insert(file_q.size(), 8'($urandom_range(1, 255)));
      file_q.insert(file_q.size(), 8'h00);
    end
    if ((flg & FLG_HCRC) != 0) begin
      repeat (2) file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_random_header();
    logic [7:0]  flg;
    logic [15:0] id;
    logic [15:0] ver;
    flg = 8'($urandom_range(0, 255)) | FLG_EXTRA;
    start_header(flg);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 99) < 60) begin
        ver = ($urandom_range(0, 99) < 95) ? dzhp_pkg::RA_VERSION
                                           : 16'($urandom_range(0, 65535));
        add_ra_sub(ver, 16'($urandom_range(0, 65535)),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
      end else begin
        id = 16'($urandom_range(0, 65535));
        if (id == dzhp_pkg::RA_ID) id[0] = ~id[0];
        add_other_sub(id, 16'($urandom_range(0, 6)));
      end
    end
    close_extra(($urandom_range(0, 99) < 80) ? 0 : $urandom_range(0, 6) - 3);
    add_tail(flg);
  endtask

  // Mostly well-formed headers with random content, some broken, some noise.
  task automatic send_random_file();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      build_random_header();
      send_file(file_q.size());
      send_noise($urandom_range(0, 2));
    end else if (pick < 85) begin
      build_random_header();
      if ($urandom_range(0, 1) == 0) begin
        // corrupt magic, method or flags
        idx = $urandom_range(0, 3);
        file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
        send_file(file_q.size());
      end else begin
        // truncate; the next start abandons the parse
        send_file($urandom_range(1, file_q.size() - 1));
      end
    end else begin
      send_noise($urandom_range(1, 4));
    end
  endtask

  // Drop valid and hold until every owed record has come back.
  task automatic settle();
    @(negedge clk);
    byte_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int dir_bytes;
    byte_valid    = 1'b0;
    byte_data     = '0;
    hold_requests = 0;
    bytes_sent    = 0;
    set_idling(0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Bytes before any start are dropped.
    send_noise(2);
    // Magic, method and flag checks, each failing on the byte it tests.
    send_beat(8'h00, 1'b1);
    send_beat(dzhp_pkg::GZ_ID1, 1'b1);
    send_beat(8'h8a, 1'b0);
    send_beat(dzhp_pkg::GZ_ID1, 1'b1);
    send_beat(dzhp_pkg::GZ_ID2, 1'b0);
    send_beat(8'h09, 1'b0);
    send_beat(dzhp_pkg::GZ_ID1, 1'b1);
    send_beat(dzhp_pkg::GZ_ID2, 1'b0);
    send_beat(dzhp_pkg::GZ_DEFLATE, 1'b0);
    send_beat(8'hfb, 1'b0);
    // RA subfield with a bad version.
    start_header(FLG_EXTRA);
    add_ra_sub(16'd2, 16'h1000, 0);
    close_extra(0);
    send_file(file_q.size());
    // Last header byte is a chunk size: completion slips to the next byte.
    start_header(FLG_EXTRA);
    add_ra_sub(dzhp_pkg::RA_VERSION, 16'hffff, 2);
    close_extra(0);
    send_file(file_q.size());
    send_noise(2);
    // All flags set: empty subfield, two RA tables, an overrunning subfield,
    // then name, comment and header CRC.
    start_header(8'hff);
    add_other_sub(16'h4142, 0);
    add_ra_sub(dzhp_pkg::RA_VERSION, 16'h0000, 1);
    add_ra_sub(dzhp_pkg::RA_VERSION, 16'h1234, 3);
    add_other_sub(16'hffff, 5);
    close_extra(-3);
    add_tail(8'hff);
    send_file(file_q.size());
    // Restart in the middle of an RA subfield, before its chunk count, then an empty extra field.
    start_header(FLG_EXTRA);
    add_ra_sub(dzhp_pkg::RA_VERSION, 16'h8000, 4);
    close_extra(0);
    send_file(20);
    start_header(FLG_EXTRA);
    close_extra(0);
    send_file(file_q.size());
    send_noise(2);
    settle();
    dir_bytes = bytes_sent;

    for (int mode = 0; mode < 3; mode++) begin
      set_idling(mode);
      if (mode == 2) begin
        // Long consumer hold-off while a long chunk table streams in.
        hold_requests++;
        start_header(FLG_EXTRA);
        add_ra_sub(dzhp_pkg::RA_VERSION, 16'($urandom_range(0, 65535)), 16);
        close_extra(0);
        send_file(file_q.size());
      end
      while (bytes_sent < dir_bytes + (ITEM_TARGET - dir_bytes) * (mode + 1) / 3)
        send_random_file();
      settle();
    end

    if (sb.fail_count == 0) begin
      $display("dictzip_header_parser: match");
    end else begin
      $display("dictzip_header_parser: mismatch");
    end
    $finish;
  end

endmodule
